/* sv/clg_pkg.sv */
package clg_pkg;

  localparam int NUM_CELLS = 1024;
  localparam int CELL_W    = 10;
  localparam int BOUND_TOL = 0;

  localparam int CMD_W = 3;
  localparam int K_W   = 17;
  localparam int LIM_W = 17;

  localparam logic [LIM_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_IBND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BBND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ILIM = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BLIM = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd6;

  // divider operand widths: dividend magnitude below 2^48, divisor below 2^49
  localparam int DVD_W  = 49;
  localparam int DVS_W  = 50;
  localparam int EXT_W  = 50;
  localparam int PROD_W = 65;
  localparam int SAT_W  = 51;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CELL_W-1:0]  cell_idx;
    logic [CELL_W-1:0]  neighbour;
    logic signed [31:0] sample;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_idx;
    logic [LIM_W-1:0]   limit;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic hi_same;
    hi_same = (v[SAT_W-1:31] == '0) || (v[SAT_W-1:31] == '1);
    if (hi_same) begin
      return v[31:0];
    end else if (v[SAT_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

/* sv/clg_ram.sv */
module clg_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/clg_div.sv */
module clg_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [clg_pkg::DVD_W-1:0]   dvd,
  input  logic signed [clg_pkg::DVS_W-1:0]   dvs,
  output logic                               done,
  output logic signed [clg_pkg::DVD_W-1:0]   quo
);
  import clg_pkg::*;

  localparam int STEPS = DVD_W - 1;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-2:0] num_r;
  logic [DVS_W-2:0] den_r;
  logic             neg_r;
  logic             zero_r;

  logic [DVD_W-1:0] dvd_mag;
  logic [DVS_W-1:0] dvs_mag;
  logic [DVS_W-1:0] rem_sh;
  logic             ge;

  assign dvd_mag = dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
  assign dvs_mag = dvs[DVS_W-1] ? DVS_W'(-dvs) : DVS_W'(dvs);
  assign rem_sh  = {rem_r[DVS_W-2:0], num_r[DVD_W-2]};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(STEPS - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dvd_mag[DVD_W-2:0];
      den_r  <= dvs_mag[DVS_W-2:0];
      neg_r  <= dvd[DVD_W-1] ^ dvs[DVS_W-1];
      zero_r <= (dvs == '0);
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[DVD_W-3:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  // division by zero reports zero
  assign quo  = zero_r ? '0 : (neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r}));

endmodule

/* sv/clg_front.sv */
module clg_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  clg_pkg::item_t            in_item,
  input  logic [clg_pkg::K_W-1:0]   relax_k,
  output logic                      q_valid,
  output clg_pkg::item_t            q_item,
  input  logic                      q_pop
);
  import clg_pkg::*;

  item_t      ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic accept, keep, c_ok, n_ok, is_lim, do_wr, do_rd;

  assign full   = (cnt_r == 2'd2);
  assign accept = push && !full;
  assign c_ok   = 32'(in_item.cell_idx) < NUM_CELLS;
  assign n_ok   = 32'(in_item.neighbour) < NUM_CELLS;
  assign is_lim = (in_item.command == CMD_ILIM) || (in_item.command == CMD_BLIM);

  // drop requests that can have no effect
  always_comb begin
    keep = c_ok;
    if (in_item.command == CMD_ILIM || in_item.command == CMD_IBND) begin
      keep = keep && n_ok;
    end
    if (is_lim && relax_k == '0) begin
      keep = 1'b0;
    end
    if (in_item.command > CMD_READ) begin
      keep = 1'b0;
    end
  end

  assign do_wr = accept && keep;
  assign do_rd = q_pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

endmodule

/* sv/clg_back.sv */
module clg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [clg_pkg::K_W-1:0]   relax_k,
  input  logic                      q_valid,
  input  clg_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_pop,
  output clg_pkg::result_t          out_res
);
  import clg_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SETTLE   = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_IB_N     = 5'd3;
  localparam logic [4:0] S_IB_C     = 5'd4;
  localparam logic [4:0] S_IB_W     = 5'd5;
  localparam logic [4:0] S_FIN_MUL  = 5'd6;
  localparam logic [4:0] S_FIN_DIV  = 5'd7;
  localparam logic [4:0] S_FIN_WAIT = 5'd8;
  localparam logic [4:0] S_FIN_WR   = 5'd9;
  localparam logic [4:0] S_LM_D     = 5'd10;
  localparam logic [4:0] S_LM_MUL   = 5'd11;
  localparam logic [4:0] S_LM_ACC   = 5'd12;
  localparam logic [4:0] S_LM_CMP   = 5'd13;
  localparam logic [4:0] S_LM_WAIT  = 5'd14;
  localparam logic [4:0] S_LM_NEXT  = 5'd15;
  localparam logic [4:0] S_RD_MUL   = 5'd16;
  localparam logic [4:0] S_RD_ACC   = 5'd17;
  localparam logic [4:0] S_RD_OUT   = 5'd18;

  logic [4:0]        state_r, state_nxt;
  logic [4:0]        ret_r, ret_nxt;
  logic [CELL_W-1:0] tgt_r, tgt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]   cmd_r;
  logic [CELL_W-1:0]  c_r, n_r;
  logic signed [31:0] samp_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] gin_r [3];
  logic signed [32:0] d_r [3];
  logic signed [31:0] g_r [3];
  logic signed [31:0] res_r [3];
  logic [1:0]         ax_r;
  logic signed [31:0] a_r, b_r, up_r, lo_r;
  logic [LIM_W-1:0]   lim_r;
  logic signed [EXT_W-1:0]  ext_r;
  logic signed [PROD_W-1:0] prod_r;
  logic               second_r;
  result_t            out_r;

  logic [31:0]  val_q;
  logic [191:0] geo_q;
  logic [63:0]  bnd_q;
  logic [LIM_W-1:0] lim_q;
  logic val_we, geo_we, bnd_we, lim_we;
  logic [63:0]      bnd_wd;
  logic [LIM_W-1:0] lim_wd;
  logic [191:0]     geo_wd;

  logic                     div_start, div_done;
  logic signed [DVD_W-1:0]  div_dvd, div_quo;
  logic signed [DVS_W-1:0]  div_dvs;

  logic signed [32:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [48:0]       term;
  logic [LIM_W-1:0]         ratio;
  logic                     relax_on, hi_viol, lo_viol;
  logic signed [EXT_W-1:0]  up_x, lo_x;

  clg_ram #(.W(32), .D(NUM_CELLS)) u_val (
    .clk(clk), .we(val_we), .waddr(tgt_r), .wdata(samp_r), .raddr(tgt_r), .rdata(val_q)
  );
  clg_ram #(.W(192), .D(NUM_CELLS)) u_geo (
    .clk(clk), .we(geo_we), .waddr(tgt_r), .wdata(geo_wd), .raddr(tgt_r), .rdata(geo_q)
  );
  clg_ram #(.W(64), .D(NUM_CELLS)) u_bnd (
    .clk(clk), .we(bnd_we), .waddr(tgt_r), .wdata(bnd_wd), .raddr(tgt_r), .rdata(bnd_q)
  );
  clg_ram #(.W(LIM_W), .D(NUM_CELLS)) u_lim (
    .clk(clk), .we(lim_we), .waddr(tgt_r), .wdata(lim_wd), .raddr(tgt_r), .rdata(lim_q)
  );

  clg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dvs(div_dvs),
    .done(div_done), .quo(div_quo)
  );

  // bound word: upper in the high half, lower in the low half
  function automatic logic [63:0] widen(input logic [63:0] bnd, input logic signed [31:0] v);
    logic signed [31:0] ub, lb;
    ub = bnd[63:32];
    lb = bnd[31:0];
    if (v > ub) ub = v;
    if (v < lb) lb = v;
    return {ub, lb};
  endfunction

  assign geo_wd   = {pos_r[2], pos_r[1], pos_r[0], gin_r[2], gin_r[1], gin_r[0]};
  assign relax_on = (relax_k != '0) && (relax_k < ONE_Q16);
  assign term     = prod_r[PROD_W-1:16];
  assign up_x     = {{(EXT_W-32){up_r[31]}}, up_r};
  assign lo_x     = {{(EXT_W-32){lo_r[31]}}, lo_r};
  assign hi_viol  = ext_r > (up_x + EXT_W'(BOUND_TOL));
  assign lo_viol  = ext_r < (lo_x - EXT_W'(BOUND_TOL));

  always_comb begin
    if (div_quo < 0) begin
      ratio = '0;
    end else if (div_quo > $signed({{(DVD_W-LIM_W){1'b0}}, ONE_Q16})) begin
      ratio = ONE_Q16;
    end else begin
      ratio = div_quo[LIM_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_FIN_MUL: begin
        mul_a = {up_r[31], up_r} - {lo_r[31], lo_r};
        mul_b = {15'd0, LIM_W'(ONE_Q16 - relax_k)};
      end
      S_LM_MUL: begin
        mul_a = d_r[ax_r];
        mul_b = g_r[ax_r];
      end
      S_RD_MUL: begin
        mul_a = {16'd0, lim_r};
        mul_b = g_r[ax_r];
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    tgt_nxt   = tgt_r;
    q_pop     = 1'b0;
    val_we    = 1'b0;
    geo_we    = 1'b0;
    bnd_we    = 1'b0;
    lim_we    = 1'b0;
    bnd_wd    = bnd_q;
    lim_wd    = ONE_Q16;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          tgt_nxt   = q_item.cell_idx;
          ret_nxt   = S_DISP;
          state_nxt = S_SETTLE;
        end
      end
      // ram read data is registered, so a new address needs the settle state first
      S_SETTLE: state_nxt = ret_r;
      S_DISP: begin
        unique case (cmd_r)
          CMD_LOAD: begin
            val_we    = 1'b1;
            geo_we    = 1'b1;
            bnd_we    = 1'b1;
            bnd_wd    = {samp_r, samp_r};
            state_nxt = S_IDLE;
          end
          CMD_IBND: begin
            tgt_nxt   = n_r;
            ret_nxt   = S_IB_N;
            state_nxt = S_SETTLE;
          end
          CMD_BBND: begin
            bnd_we    = 1'b1;
            bnd_wd    = widen(bnd_q, samp_r);
            state_nxt = S_IDLE;
          end
          CMD_FIN:  state_nxt = relax_on ? S_FIN_MUL : S_FIN_WR;
          CMD_ILIM: state_nxt = S_LM_D;
          CMD_BLIM: state_nxt = S_LM_D;
          CMD_READ: state_nxt = S_RD_MUL;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_IB_N: begin
        tgt_nxt   = c_r;
        ret_nxt   = S_IB_C;
        state_nxt = S_SETTLE;
      end
      S_IB_C: begin
        bnd_we    = 1'b1;
        bnd_wd    = widen(bnd_q, b_r);
        tgt_nxt   = n_r;
        ret_nxt   = S_IB_W;
        state_nxt = S_SETTLE;
      end
      S_IB_W: begin
        bnd_we    = 1'b1;
        bnd_wd    = widen(bnd_q, a_r);
        state_nxt = S_IDLE;
      end
      S_FIN_MUL: state_nxt = S_FIN_DIV;
      S_FIN_DIV: begin
        div_start = 1'b1;
        div_dvd   = prod_r[DVD_W-1:0];
        div_dvs   = {{(DVS_W-K_W){1'b0}}, relax_k};
        state_nxt = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        bnd_we    = 1'b1;
        bnd_wd    = {up_r, lo_r};
        lim_we    = 1'b1;
        lim_wd    = ONE_Q16;
        state_nxt = S_IDLE;
      end
      S_LM_D:   state_nxt = S_LM_MUL;
      S_LM_MUL: state_nxt = S_LM_ACC;
      S_LM_ACC: state_nxt = (ax_r == 2'd2) ? S_LM_CMP : S_LM_MUL;
      S_LM_CMP: begin
        priority if (hi_viol) begin
          div_start = 1'b1;
          div_dvd   = {up_r[31], up_r, 16'd0};
          div_dvs   = ext_r;
          state_nxt = S_LM_WAIT;
        end else if (lo_viol) begin
          div_start = 1'b1;
          div_dvd   = {lo_r[31], lo_r, 16'd0};
          div_dvs   = ext_r;
          state_nxt = S_LM_WAIT;
        end else begin
          state_nxt = S_LM_NEXT;
        end
      end
      S_LM_WAIT: begin
        if (div_done) begin
          if (ratio < lim_r) begin
            lim_we = 1'b1;
            lim_wd = ratio;
          end
          state_nxt = S_LM_NEXT;
        end
      end
      S_LM_NEXT: begin
        if (cmd_r == CMD_ILIM && !second_r) begin
          tgt_nxt   = n_r;
          ret_nxt   = S_LM_D;
          state_nxt = S_SETTLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_MUL: state_nxt = S_RD_ACC;
      S_RD_ACC: state_nxt = (ax_r == 2'd2) ? S_RD_OUT : S_RD_MUL;
      S_RD_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_r    <= q_item.command;
          c_r      <= q_item.cell_idx;
          n_r      <= q_item.neighbour;
          samp_r   <= q_item.sample;
          gin_r[0] <= q_item.grad_x;
          gin_r[1] <= q_item.grad_y;
          gin_r[2] <= q_item.grad_z;
          pos_r[0] <= q_item.pos_x;
          pos_r[1] <= q_item.pos_y;
          pos_r[2] <= q_item.pos_z;
          second_r <= 1'b0;
        end
      end
      S_DISP: begin
        a_r  <= val_q;
        ax_r <= 2'd0;
        up_r <= sat32(SAT_W'($signed(bnd_q[63:32])) - SAT_W'($signed(val_q)));
        lo_r <= sat32(SAT_W'($signed(bnd_q[31:0])) - SAT_W'($signed(val_q)));
        for (int i = 0; i < 3; i++) begin
          g_r[i] <= geo_q[i*32 +: 32];
        end
        if (relax_k == '0 || lim_q > ONE_Q16) begin
          lim_r <= ONE_Q16;
        end else begin
          lim_r <= lim_q;
        end
      end
      S_IB_N: b_r <= val_q;
      S_FIN_MUL: prod_r <= mul_p;
      S_FIN_WAIT: begin
        if (div_done) begin
          up_r <= sat32(SAT_W'(up_r) + SAT_W'(div_quo));
          lo_r <= sat32(SAT_W'(lo_r) - SAT_W'(div_quo));
        end
      end
      S_LM_D: begin
        for (int i = 0; i < 3; i++) begin
          d_r[i] <= 33'(pos_r[i]) - 33'($signed(geo_q[96 + i*32 +: 32]));
          g_r[i] <= geo_q[i*32 +: 32];
        end
        up_r  <= bnd_q[63:32];
        lo_r  <= bnd_q[31:0];
        lim_r <= lim_q;
        ext_r <= '0;
        ax_r  <= 2'd0;
      end
      S_LM_MUL: prod_r <= mul_p;
      S_LM_ACC: begin
        ext_r <= ext_r + EXT_W'(term);
        ax_r  <= ax_r + 2'd1;
      end
      S_LM_NEXT: second_r <= 1'b1;
      S_RD_MUL: prod_r <= mul_p;
      S_RD_ACC: begin
        res_r[ax_r] <= sat32(SAT_W'(term));
        ax_r        <= ax_r + 2'd1;
      end
      S_RD_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_r.cell_idx <= c_r;
          out_r.limit    <= lim_r;
          out_r.x        <= res_r[0];
          out_r.y        <= res_r[1];
          out_r.z        <= res_r[2];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

/* sv/cell_gradient_limiter.sv */
// cell gradient limiter, relaxed min-max scheme in Q16.16
// input queue: drive in_* with push; a request is taken when push is high and
// full is low. commands run load, bound, finalize, limit, read per mesh pass.
// result queue: a read request yields one result on out_cell and the out_*
// ports while empty is low; pop takes it. other commands yield no result.
// config: cfg_relax_k is written when cfg_valid is high (cfg_ready is always
// high); write it only while no request is in flight.
// a two-entry queue sits between the front, which drops requests that have
// no effect, and the back sequencer, which owns the cell memories.
// in the back, finalize with k above zero and below one, and a limit request
// that finds a bound exceeded, wait on the 48-step serial divider; the other
// requests are paced by the single-address cell memories.
// a result waiting on a stalled receiver holds the back only when the next
// read result is ready; full rises once the input queue holds two requests.
// reset empties both queues and sets relax_k to one; cell memories are not
// cleared and must be loaded before use.
module cell_gradient_limiter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [clg_pkg::CMD_W-1:0]          in_command,
  input  logic [clg_pkg::CELL_W-1:0]         in_cell_index,
  input  logic [clg_pkg::CELL_W-1:0]         in_neighbour_index,
  input  logic signed [31:0]                 in_sample_value,
  input  logic signed [31:0]                 in_grad_x,
  input  logic signed [31:0]                 in_grad_y,
  input  logic signed [31:0]                 in_grad_z,
  input  logic signed [31:0]                 in_pos_x,
  input  logic signed [31:0]                 in_pos_y,
  input  logic signed [31:0]                 in_pos_z,
  output logic                               empty,
  input  logic                               pop,
  output logic [clg_pkg::CELL_W-1:0]         out_cell,
  output logic [clg_pkg::LIM_W-1:0]          out_limit_factor,
  output logic signed [31:0]                 out_limited_x,
  output logic signed [31:0]                 out_limited_y,
  output logic signed [31:0]                 out_limited_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [clg_pkg::K_W-1:0]            cfg_relax_k
);
  import clg_pkg::*;

  logic [K_W-1:0] relax_k_r;
  item_t          in_item, q_item;
  result_t        res;
  logic           q_valid, q_pop, out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_k_r <= ONE_Q16;
    end else if (cfg_valid) begin
      relax_k_r <= cfg_relax_k;
    end
  end

  assign in_item = '{command: in_command, cell_idx: in_cell_index,
                     neighbour: in_neighbour_index,
                     sample: in_sample_value, grad_x: in_grad_x, grad_y: in_grad_y,
                     grad_z: in_grad_z, pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z};

  clg_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .relax_k(relax_k_r), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  clg_back u_back (
    .clk(clk), .rst_n(rst_n), .relax_k(relax_k_r), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_valid(out_valid), .out_pop(pop), .out_res(res)
  );

  assign empty            = !out_valid;
  assign out_cell         = res.cell_idx;
  assign out_limit_factor = res.limit;
  assign out_limited_x    = res.x;
  assign out_limited_y    = res.y;
  assign out_limited_z    = res.z;

endmodule

/* bench/cell_gradient_limiter_tb.sv */
`timescale 1ns / 1ps

module cell_gradient_limiter_tb;
  import clg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [CMD_W-1:0] in_command;
  logic [CELL_W-1:0] in_cell_index;
  logic [CELL_W-1:0] in_neighbour_index;
  logic signed [31:0] in_sample_value;
  logic signed [31:0] in_grad_x, in_grad_y, in_grad_z;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic empty;
  logic pop;
  logic [CELL_W-1:0] out_cell;
  logic [LIM_W-1:0] out_limit_factor;
  logic signed [31:0] out_limited_x, out_limited_y, out_limited_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [K_W-1:0] cfg_relax_k;

  cell_gradient_limiter uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(in_command), .in_cell_index(in_cell_index),
    .in_neighbour_index(in_neighbour_index), .in_sample_value(in_sample_value),
    .in_grad_x(in_grad_x), .in_grad_y(in_grad_y), .in_grad_z(in_grad_z),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .empty(empty), .pop(pop), .out_cell(out_cell),
    .out_limit_factor(out_limit_factor), .out_limited_x(out_limited_x),
    .out_limited_y(out_limited_y), .out_limited_z(out_limited_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_relax_k(cfg_relax_k)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // mirror of the block state
  int relax_k_m;
  int cell_val_m [0:NUM_CELLS-1];
  int grad_m [0:NUM_CELLS-1][0:2];
  int centre_m [0:NUM_CELLS-1][0:2];
  int upper_m [0:NUM_CELLS-1];
  int lower_m [0:NUM_CELLS-1];
  int limiter_m [0:NUM_CELLS-1];

  item_t pending_requests[$];
  result_t expected_results[$];
  int fail_count = 0;

  // generator side bookkeeping
  bit ever_final [0:NUM_CELLS-1];
  int gen_centre [0:NUM_CELLS-1][0:2];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void widen_bounds(input int c, input int v);
    if (v > upper_m[c]) upper_m[c] = v;
    if (v < lower_m[c]) lower_m[c] = v;
  endfunction

  function automatic void cap_limiter(input int c, input item_t it);
    logic signed [65:0] ext, d, prod, bnd, ratio;
    int face [3];
    ext = '0;
    face[0] = it.pos_x;
    face[1] = it.pos_y;
    face[2] = it.pos_z;
    for (int a = 0; a < 3; a++) begin
      d = 66'(longint'(face[a]) - longint'(centre_m[c][a]));
      prod = d * 66'(longint'(grad_m[c][a]));
      ext = ext + (prod >>> 16);
    end
    if (ext > 66'(longint'(upper_m[c]) + BOUND_TOL)) begin
      bnd = 66'(longint'(upper_m[c]));
    end else if (ext < 66'(longint'(lower_m[c]) - BOUND_TOL)) begin
      bnd = 66'(longint'(lower_m[c]));
    end else begin
      return;
    end
    if (ext == 0) begin
      ratio = 0;
    end else begin
      ratio = (bnd * 66'sd65536) / ext;
    end
    if (ratio < 0) ratio = 0;
    if (ratio > 66'sd65536) ratio = 66'sd65536;
    if (int'(ratio) < limiter_m[c]) limiter_m[c] = int'(ratio);
  endfunction

  function automatic void apply_request(input item_t it);
    int c, n, vc, vn, lim;
    longint up, lo, e;
    result_t r;
    c = it.cell_idx;
    n = it.neighbour;
    case (it.command)
      CMD_LOAD: begin
        cell_val_m[c] = it.sample;
        grad_m[c][0] = it.grad_x;
        grad_m[c][1] = it.grad_y;
        grad_m[c][2] = it.grad_z;
        centre_m[c][0] = it.pos_x;
        centre_m[c][1] = it.pos_y;
        centre_m[c][2] = it.pos_z;
        upper_m[c] = it.sample;
        lower_m[c] = it.sample;
      end
      CMD_IBND: begin
        vc = cell_val_m[c];
        vn = cell_val_m[n];
        widen_bounds(c, vn);
        widen_bounds(n, vc);
      end
      CMD_BBND: widen_bounds(c, it.sample);
      CMD_FIN: begin
        up = clip32(longint'(upper_m[c]) - longint'(cell_val_m[c]));
        lo = clip32(longint'(lower_m[c]) - longint'(cell_val_m[c]));
        if (relax_k_m != 0 && relax_k_m < 65536) begin
          e = ((up - lo) * longint'(65536 - relax_k_m)) / longint'(relax_k_m);
          up = up + e;
          lo = lo - e;
        end
        upper_m[c] = int'(clip32(up));
        lower_m[c] = int'(clip32(lo));
        limiter_m[c] = 65536;
      end
      CMD_ILIM: begin
        if (relax_k_m != 0) begin
          cap_limiter(c, it);
          cap_limiter(n, it);
        end
      end
      CMD_BLIM: if (relax_k_m != 0) cap_limiter(c, it);
      CMD_READ: begin
        lim = limiter_m[c];
        if (lim > 65536) lim = 65536;
        if (relax_k_m == 0) lim = 65536;
        r.cell_idx = c[CELL_W-1:0];
        r.limit = lim[LIM_W-1:0];
        r.x = int'(clip32((longint'(grad_m[c][0]) * lim) >>> 16));
        r.y = int'(clip32((longint'(grad_m[c][1]) * lim) >>> 16));
        r.z = int'(clip32((longint'(grad_m[c][2]) * lim) >>> 16));
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // sender: bursts with random gaps
  int burst_left, gap_left;

  always @(posedge clk) begin
    bit taken;
    int remaining;
    item_t nx;
    if (!rst_n) begin
      push <= 1'b0;
      in_command <= '0;
      in_cell_index <= '0;
      in_neighbour_index <= '0;
      in_sample_value <= '0;
      in_grad_x <= '0;
      in_grad_y <= '0;
      in_grad_z <= '0;
      in_pos_x <= '0;
      in_pos_y <= '0;
      in_pos_z <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      taken = push && !full;
      if (taken) begin
        apply_request(pending_requests[0]);
        void'(pending_requests.pop_front());
      end
      remaining = pending_requests.size();
      if (push && !taken) begin
        push <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (remaining > 0) begin
        nx = pending_requests[0];
        push <= 1'b1;
        in_command <= nx.command;
        in_cell_index <= nx.cell_idx;
        in_neighbour_index <= nx.neighbour;
        in_sample_value <= nx.sample;
        in_grad_x <= nx.grad_x;
        in_grad_y <= nx.grad_y;
        in_grad_z <= nx.grad_z;
        in_pos_x <= nx.pos_x;
        in_pos_y <= nx.pos_y;
        in_pos_z <= nx.pos_z;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  logic hold_off;
  int stall_mode, stall_pos;
  logic [15:0] stall_bits;

  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (900) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_mode <= 0;
      stall_pos <= 0;
      stall_bits <= 16'hffff;
    end else begin
      if (stall_pos == 63) begin
        stall_mode <= $urandom_range(2);
        stall_bits <= 16'($urandom);
        stall_pos <= 0;
      end else begin
        stall_pos <= stall_pos + 1;
      end
      if (hold_off) pop <= 1'b0;
      else if (stall_mode == 0) pop <= 1'b1;
      else pop <= stall_bits[stall_pos % 16];
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result for cell %0d", $time, out_cell);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_cell !== exp_r.cell_idx) begin
          $display("%0t: out_cell expected %0d actual %0d", $time, exp_r.cell_idx,
                   out_cell);
          fail_count++;
        end
        if (out_limit_factor !== exp_r.limit) begin
          $display("%0t: limit_factor cell %0d expected %0d actual %0d", $time,
                   exp_r.cell_idx, exp_r.limit, out_limit_factor);
          fail_count++;
        end
        if (out_limited_x !== exp_r.x) begin
          $display("%0t: limited_x cell %0d expected %0d actual %0d", $time,
                   exp_r.cell_idx, exp_r.x, out_limited_x);
          fail_count++;
        end
        if (out_limited_y !== exp_r.y) begin
          $display("%0t: limited_y cell %0d expected %0d actual %0d", $time,
                   exp_r.cell_idx, exp_r.y, out_limited_y);
          fail_count++;
        end
        if (out_limited_z !== exp_r.z) begin
          $display("%0t: limited_z cell %0d expected %0d actual %0d", $time,
                   exp_r.cell_idx, exp_r.z, out_limited_z);
          fail_count++;
        end
      end
    end
  end

  task automatic add_request(input logic [CMD_W-1:0] cmd, input int c, input int n,
                             input int s, input int gx, input int gy, input int gz,
                             input int px, input int py, input int pz);
    item_t it;
    it.command = cmd;
    it.cell_idx = c[CELL_W-1:0];
    it.neighbour = n[CELL_W-1:0];
    it.sample = s;
    it.grad_x = gx;
    it.grad_y = gy;
    it.grad_z = gz;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    if (cmd == CMD_LOAD) begin
      gen_centre[c][0] = px;
      gen_centre[c][1] = py;
      gen_centre[c][2] = pz;
    end
    if (cmd == CMD_FIN) ever_final[c] = 1'b1;
    pending_requests.push_back(it);
  endtask

  function automatic int rand_value();
    if ($urandom_range(7) == 0) return $urandom;
    return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
  endfunction

  function automatic int rand_grad();
    if ($urandom_range(7) == 0) return $urandom;
    return int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(5) == 0) return int'($urandom) >>> 1;
    return int'($urandom_range(0, 2 ** 23)) - 2 ** 22;
  endfunction

  function automatic int near(input int base);
    return base + int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
  endfunction

  task automatic add_noise(input int ids[$]);
    int c;
    c = ids[$urandom_range(ids.size() - 1)];
    case ($urandom_range(2))
      0: add_request(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023), $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      1: if (ever_final[c]) add_request(CMD_READ, c, $urandom_range(1023), $urandom,
                                        0, 0, 0, 0, 0, 0);
      default: if (ever_final[c])
        add_request(CMD_BLIM, c, $urandom_range(1023), $urandom, 0, 0, 0,
                    near(gen_centre[c][0]), near(gen_centre[c][1]),
                    near(gen_centre[c][2]));
    endcase
  endtask

  // one mesh pass: load, bound, finalize, limit, read over a few cells
  task automatic mesh_pass();
    int ids[$];
    int cnt, c, n;
    bit dup;
    cnt = $urandom_range(3, 6);
    while (ids.size() < cnt) begin
      c = $urandom_range(1023);
      dup = 1'b0;
      foreach (ids[i]) if (ids[i] == c) dup = 1'b1;
      if (!dup) ids.push_back(c);
    end
    foreach (ids[i]) begin
      add_request(CMD_LOAD, ids[i], $urandom_range(1023), rand_value(), rand_grad(),
                  rand_grad(), rand_grad(), rand_pos(), rand_pos(), rand_pos());
      if ($urandom_range(9) == 0) add_noise(ids);
    end
    repeat (cnt) begin
      c = ids[$urandom_range(cnt - 1)];
      n = ids[$urandom_range(cnt - 1)];
      if ($urandom_range(3) == 0)
        add_request(CMD_BBND, c, $urandom_range(1023), rand_value(), $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        add_request(CMD_IBND, c, n, $urandom, 0, 0, 0, 0, 0, 0);
    end
    foreach (ids[i]) add_request(CMD_FIN, ids[i], $urandom_range(1023), $urandom,
                                 0, 0, 0, 0, 0, 0);
    repeat (2 * cnt) begin
      c = ids[$urandom_range(cnt - 1)];
      n = ids[$urandom_range(cnt - 1)];
      if ($urandom_range(1) == 0)
        add_request(CMD_ILIM, c, n, $urandom, 0, 0, 0, near(gen_centre[c][0]),
                    near(gen_centre[c][1]), near(gen_centre[c][2]));
      else
        add_request(CMD_BLIM, c, $urandom_range(1023), $urandom, 0, 0, 0,
                    near(gen_centre[c][0]), near(gen_centre[c][1]),
                    near(gen_centre[c][2]));
      if ($urandom_range(9) == 0) add_noise(ids);
    end
    foreach (ids[i]) add_request(CMD_READ, ids[i], $urandom_range(1023), $urandom,
                                 0, 0, 0, 0, 0, 0);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || push || expected_results.size() != 0);
    // requests with no result may still be running
    repeat (300) @(posedge clk);
  endtask

  task automatic write_relax_k(input int k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_relax_k <= k[K_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    relax_k_m = k;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int k_list[$];
    relax_k_m = 65536;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_relax_k = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_relax_k(65536);
    // directed: field extremes, saturation, every command, unused command
    add_request(CMD_LOAD, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 65536,
                32'h7fffffff, 32'h80000000, 0);
    add_request(CMD_LOAD, 1023, 1023, 32'h80000000, 65536, -65536, 0, 0, 0, 0);
    add_request(CMD_LOAD, 5, 0, 0, 131072, 0, 0, 0, 0, 0);
    add_request(CMD_IBND, 0, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_IBND, 5, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_BBND, 5, 0, 10 * 65536, 0, 0, 0, 0, 0, 0);
    add_request(CMD_BBND, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0);
    add_request(CMD_FIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_FIN, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_FIN, 5, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_ILIM, 0, 5, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
    add_request(CMD_BLIM, 5, 0, 0, 0, 0, 0, 20 * 65536, 0, 0);
    add_request(CMD_BLIM, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_BLIM, 1023, 0, 0, 0, 0, 0, -3 * 65536, 65536, 0);
    add_request(CMD_UNUSED, 5, 5, 32'hffffffff, -1, -1, -1, -1, -1, -1);
    add_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_READ, 5, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    // limiting disabled on cells already limited
    write_relax_k(0);
    add_request(CMD_BLIM, 5, 0, 0, 0, 0, 0, 40 * 65536, 0, 0);
    add_request(CMD_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    k_list = '{1, 32768, 0, 65535, 65536, -1, 16384, 65536};
    foreach (k_list[i]) begin
      write_relax_k((k_list[i] < 0) ? $urandom_range(1, 65535) : k_list[i]);
      repeat (2) mesh_pass();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
sv/clg_pkg.sv
sv/clg_ram.sv
sv/clg_div.sv
sv/clg_front.sv
sv/clg_back.sv
sv/cell_gradient_limiter.sv
bench/cell_gradient_limiter_tb.sv
